### rtl/core/led_ring_meteor_breath_effect_assert.svh
// Assertion macros shared by the LED ring effect engine modules
`ifndef LED_RING_METEOR_BREATH_EFFECT_ASSERT_SVH
`define LED_RING_METEOR_BREATH_EFFECT_ASSERT_SVH
`ifndef SYNTHESIS
`define LRMB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lrmb assertion failed");
`define LRMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrmb assertion failed");
`else
`define LRMB_ASSERT(lbl, clk, rst_n, prop)
`define LRMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/lrmb_pkg.sv
// Types, constants and timing tables of the LED ring effect engine
`default_nettype none

package lrmb_pkg;

    localparam int LED_COUNT       = 6;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 8;
    localparam int REC_SHIFT       = 20;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_METEOR = 2'd1;
    localparam logic [1:0] MODE_BREATH = 2'd2;

    localparam logic [1:0] SPEED_SAT   = 2'd3;
    localparam logic [1:0] SPEED_MAX   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd5;

    localparam logic [7:0] LVL_MASK  = 8'h7F;
    localparam logic [7:0] LVL_FALL  = 8'h80;
    localparam logic [7:0] LVL_FLOOR = 8'h81;

    typedef enum logic {
        CMD_METEOR,
        CMD_BREATH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [2:0] pos;
        logic [6:0] lvl;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] speed;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] target;
    } t_cfg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_METEOR,
        BK_PROD,
        BK_SCALE
    } t_bk_state;

    function automatic logic [7:0] meteor_period(input logic [1:0] sp);
        logic [7:0] per;
        unique case (sp)
            2'd0:    per = 8'd200;
            2'd1:    per = 8'd140;
            default: per = 8'd80;
        endcase
        return per;
    endfunction

    function automatic logic [7:0] breath_period(input logic [1:0] sp);
        logic [7:0] per;
        unique case (sp)
            2'd0:    per = 8'd50;
            2'd1:    per = 8'd35;
            default: per = 8'd25;
        endcase
        return per;
    endfunction

    // ceil(2**REC_SHIFT / breath period), exact floor division for products below 2**14
    function automatic logic [15:0] breath_recip(input logic [1:0] sp);
        logic [15:0] rec;
        unique case (sp)
            2'd0:    rec = 16'd20972;
            2'd1:    rec = 16'd29960;
            default: rec = 16'd41944;
        endcase
        return rec;
    endfunction

    function automatic logic [2:0] tail_shift(input logic [1:0] sp);
        return 3'(sp) + 3'd3;
    endfunction

endpackage

`default_nettype wire

### rtl/core/led_ring_meteor_breath_effect.sv
// Top level of the LED ring meteor and breath effect engine
//
//  channel   direction  handshake                      payload
//  tick      in         i_tick_valid / o_tick_ready    i_tick
//  result    out        o_res_valid / i_res_ready      o_led_sel, o_out_red/green/blue,
//                                                      o_frame_last
//  config    in         i_cfg_we                       i_cfg_idx, i_cfg_wdata
//
//  A tick request is taken every cycle while the request queue has room.
//  A meteor frame is one dequeue followed by six LED writes; a breath write is a dequeue,
//  the color products and the reciprocal scale into the output register.
//  Reset is synchronous, active low; there is no clearing pass after reset.
//  A held result stalls the result engine; the queue then fills and tick ready drops.
`default_nettype none

module led_ring_meteor_breath_effect import lrmb_pkg::*; #(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_tick_valid,
    output logic                       o_tick_ready,
    input  wire logic                  i_tick,
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output logic [2:0]                 o_led_sel,
    output logic [7:0]                 o_out_red,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_blue,
    output logic                       o_frame_last
);

    t_cfg w_cfg;
    t_cmd w_push_cmd;
    t_cmd w_pop_cmd;
    logic w_push;
    logic w_pop;
    logic w_not_full;
    logic w_not_empty;

    lrmb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_tick_valid (i_tick_valid),
        .o_tick_ready (o_tick_ready),
        .i_tick       (i_tick),
        .i_q_ready    (w_not_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd),
        .o_cfg        (w_cfg)
    );

    lrmb_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_wr_data   (w_push_cmd),
        .o_not_full  (w_not_full),
        .i_pop       (w_pop),
        .o_rd_data   (w_pop_cmd),
        .o_not_empty (w_not_empty)
    );

    lrmb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_valid    (w_not_empty),
        .i_cmd        (w_pop_cmd),
        .o_pop        (w_pop),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_led_sel    (o_led_sel),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_frame_last (o_frame_last)
    );

endmodule

`default_nettype wire

### rtl/core/lrmb_front.sv
// Front end: configuration registers, tick timing and frame request generation
`default_nettype none
`include "led_ring_meteor_breath_effect_assert.svh"

module lrmb_front import lrmb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_tick_valid,
    output logic                       o_tick_ready,
    input  wire logic                  i_tick,
    input  wire logic                  i_q_ready,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    output t_cfg                       o_cfg
);

    t_cfg       r_cfg, n_cfg;
    logic [2:0] r_head, n_head;
    logic [7:0] r_level, n_level;
    logic [7:0] r_wait, n_wait;
    logic       w_restart;
    logic       w_tick;
    logic [7:0] w_mper;
    logic [7:0] w_bper;
    logic [7:0] w_lvl_inc;
    logic [7:0] w_lvl_dec;

    assign o_tick_ready = i_q_ready;
    assign o_cfg        = r_cfg;
    assign w_tick       = i_tick_valid && o_tick_ready && i_tick;
    assign w_mper       = meteor_period(r_cfg.speed);
    assign w_bper       = breath_period(r_cfg.speed);
    assign w_lvl_inc    = r_level + 8'd1;
    assign w_lvl_dec    = r_level - 8'd1;

    always_comb begin
        n_cfg     = r_cfg;
        n_head    = r_head;
        n_level   = r_level;
        n_wait    = r_wait;
        w_restart = 1'b0;
        o_push    = 1'b0;
        o_cmd     = '0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE: begin
                    n_cfg.mode = i_cfg_wdata[1:0];
                    w_restart  = 1'b1;
                end
                CFG_SPEED: begin
                    n_cfg.speed = (i_cfg_wdata[1:0] == SPEED_SAT) ? SPEED_MAX
                                                                  : i_cfg_wdata[1:0];
                    w_restart   = 1'b1;
                end
                CFG_RED: begin
                    n_cfg.red = i_cfg_wdata[7:0];
                    w_restart = 1'b1;
                end
                CFG_GREEN: begin
                    n_cfg.green = i_cfg_wdata[7:0];
                    w_restart   = 1'b1;
                end
                CFG_BLUE: begin
                    n_cfg.blue = i_cfg_wdata[7:0];
                    w_restart  = 1'b1;
                end
                CFG_TARGET: begin
                    n_cfg.target = i_cfg_wdata[2:0];
                    w_restart    = 1'b1;
                end
                default: ;
            endcase
        end
        if (w_restart) begin
            n_head  = 3'd1;
            n_level = '0;
            n_wait  = '0;
        end else if (w_tick) begin
            unique case (r_cfg.mode)
                MODE_METEOR: begin
                    if (r_wait != 8'd0) begin
                        n_wait = r_wait - 8'd1;
                    end else begin
                        n_wait    = w_mper - 8'd1;
                        o_push    = 1'b1;
                        o_cmd.kind = CMD_METEOR;
                        o_cmd.pos  = r_head;
                        n_head    = (r_head == 3'(LED_COUNT)) ? 3'd1 : r_head + 3'd1;
                    end
                end
                MODE_BREATH: begin
                    if (r_cfg.target <= 3'(LED_COUNT)) begin
                        if (r_wait != 8'd0) begin
                            n_wait = r_wait - 8'd1;
                        end else begin
                            n_wait     = w_bper - 8'd1;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_BREATH;
                            o_cmd.pos  = r_cfg.target;
                            o_cmd.lvl  = 7'(r_level & LVL_MASK);
                            if ((r_level & LVL_FALL) != 8'd0) begin
                                n_level = (w_lvl_dec <= LVL_FLOOR) ? 8'd1 : w_lvl_dec;
                            end else begin
                                n_level = (w_lvl_inc >= w_bper) ? (LVL_FALL | w_bper)
                                                                : w_lvl_inc;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_head  <= 3'd1;
            r_level <= '0;
            r_wait  <= '0;
        end else begin
            r_cfg   <= n_cfg;
            r_head  <= n_head;
            r_level <= n_level;
            r_wait  <= n_wait;
        end
    end

    `LRMB_ASSERT(a_head_range, i_clk, i_rst_n, (r_head != 3'd0) && (r_head <= 3'(LED_COUNT)))
    `LRMB_ASSERT(a_push_has_room, i_clk, i_rst_n, o_push |-> i_q_ready)

endmodule

`default_nettype wire

### rtl/core/lrmb_cmd_fifo.sv
// Short request queue between the front end and the result engine
`default_nettype none
`include "led_ring_meteor_breath_effect_assert.svh"

module lrmb_cmd_fifo import lrmb_pkg::*; #(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_wr_data,
    output logic      o_not_full,
    input  wire logic i_pop,
    output t_cmd      o_rd_data,
    output logic      o_not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_not_full  = (r_count != CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_rd_data   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    `LRMB_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `LRMB_ASSERT(a_pop_not_empty, i_clk, i_rst_n, i_pop |-> o_not_empty)

endmodule

`default_nettype wire

### rtl/core/lrmb_back.sv
// Result engine: expands frame requests into LED writes behind an output register
`default_nettype none
`include "led_ring_meteor_breath_effect_assert.svh"

module lrmb_back import lrmb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cfg            i_cfg,
    input  wire logic       i_q_valid,
    input  t_cmd            i_cmd,
    output logic            o_pop,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output logic [2:0]      o_led_sel,
    output logic [7:0]      o_out_red,
    output logic [7:0]      o_out_green,
    output logic [7:0]      o_out_blue,
    output logic            o_frame_last
);

    t_bk_state   r_state, n_state;
    logic [2:0]  r_idx, n_idx;
    logic [2:0]  r_led, n_led;
    logic [6:0]  r_lvl, n_lvl;
    logic [14:0] r_prod_r, r_prod_g, r_prod_b;
    logic        r_out_valid;
    logic [2:0]  r_led_sel;
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_last;

    logic        w_free;
    logic        w_load;
    logic        w_load_prod;
    logic [2:0]  w_sh1, w_sh2;
    logic [15:0] w_recip;
    logic [30:0] w_sc_r, w_sc_g, w_sc_b;
    logic [2:0]  w_led;
    logic [7:0]  w_red, w_green, w_blue;
    logic        w_last;

    assign w_free  = !r_out_valid || i_res_ready;
    assign w_sh1   = tail_shift(i_cfg.speed);
    assign w_sh2   = w_sh1 + 3'd1;
    assign w_recip = breath_recip(i_cfg.speed);
    assign w_sc_r  = 31'(r_prod_r) * 31'(w_recip);
    assign w_sc_g  = 31'(r_prod_g) * 31'(w_recip);
    assign w_sc_b  = 31'(r_prod_b) * 31'(w_recip);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_led       = r_led;
        n_lvl       = r_lvl;
        o_pop       = 1'b0;
        w_load      = 1'b0;
        w_load_prod = 1'b0;
        w_led       = r_led;
        w_red       = '0;
        w_green     = '0;
        w_blue      = '0;
        w_last      = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                    n_led = i_cmd.pos;
                    n_lvl = i_cmd.lvl;
                    n_state = (i_cmd.kind == CMD_METEOR) ? BK_METEOR : BK_PROD;
                end
            end
            BK_METEOR: begin
                if (w_free) begin
                    w_load = 1'b1;
                    w_last = (r_idx == 3'(LED_COUNT - 1));
                    unique case (r_idx)
                        3'd0: begin
                            w_red   = i_cfg.red;
                            w_green = i_cfg.green;
                            w_blue  = i_cfg.blue;
                        end
                        3'd1: begin
                            w_red   = i_cfg.red >> w_sh1;
                            w_green = i_cfg.green >> w_sh1;
                            w_blue  = i_cfg.blue >> w_sh1;
                        end
                        3'd2: begin
                            w_red   = i_cfg.red >> w_sh2;
                            w_green = i_cfg.green >> w_sh2;
                            w_blue  = i_cfg.blue >> w_sh2;
                        end
                        default: ;
                    endcase
                    n_led = (r_led == 3'd1) ? 3'(LED_COUNT) : r_led - 3'd1;
                    n_idx = r_idx + 3'd1;
                    if (w_last) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_PROD: begin
                w_load_prod = 1'b1;
                n_state     = BK_SCALE;
            end
            BK_SCALE: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    w_last  = 1'b1;
                    w_red   = w_sc_r[REC_SHIFT +: 8];
                    w_green = w_sc_g[REC_SHIFT +: 8];
                    w_blue  = w_sc_b[REC_SHIFT +: 8];
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_led <= n_led;
        r_lvl <= n_lvl;
        if (w_load_prod) begin
            r_prod_r <= 15'(i_cfg.red * r_lvl);
            r_prod_g <= 15'(i_cfg.green * r_lvl);
            r_prod_b <= 15'(i_cfg.blue * r_lvl);
        end
        if (w_load) begin
            r_led_sel <= w_led;
            r_red     <= w_red;
            r_green   <= w_green;
            r_blue    <= w_blue;
            r_last    <= w_last;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_led_sel    = r_led_sel;
    assign o_out_red    = r_red;
    assign o_out_green  = r_green;
    assign o_out_blue   = r_blue;
    assign o_frame_last = r_last;

    `LRMB_ASSERT(a_meteor_idx, i_clk, i_rst_n, (r_state == BK_METEOR) |-> (r_idx < 3'(LED_COUNT)))
    `LRMB_ASSERT_NEXT(a_prod_to_scale, i_clk, i_rst_n, r_state == BK_PROD, r_state == BK_SCALE)

endmodule

`default_nettype wire

### bench/tb_led_ring_meteor_breath_effect.sv
// Self-checking testbench for the LED ring meteor and breath effect engine
`timescale 1ns / 1ps

module tb_led_ring_meteor_breath_effect;
    import lrmb_pkg::*;

    localparam logic [1:0]           MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [2:0]           TARGET_ALL   = 3'd0;
    localparam logic [2:0]           TARGET_NONE  = 3'd7;

    localparam int SHORT_TICK_GOAL = 110;
    localparam int DEEP_PHASES     = 4;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 16;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    typedef struct packed {
        logic [2:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_led_write;

    typedef enum logic {
        ROW_CFG,
        ROW_TICK
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  tick;
        logic                  typed;
        t_led_write            want;
    } t_dir_row;

    localparam t_led_write NO_WRITE = '0;

    localparam int DIR_ROWS = 35;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b0, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_SPEED,    8'h03, 1'b0, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_RED,      8'hFF, 1'b0, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_GREEN,    8'hFF, 1'b0, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_BLUE,     8'hFF, 1'b0, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_MODE,     8'h01, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b1, '{3'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_SPEED,    8'h00, 1'b0, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_RED,      8'h80, 1'b0, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_GREEN,    8'h7F, 1'b0, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_BLUE,     8'h01, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b1, '{3'd1, 8'h80, 8'h7F, 8'h01, 1'b0}},
        '{ROW_CFG,  CFG_SPARE_LO, 8'hFF, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_SPARE_HI, 8'h00, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_SPEED,    8'h01, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_MODE,     8'h02, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b1, '{TARGET_ALL, 8'h00, 8'h00, 8'h00, 1'b1}},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_TARGET,   8'h06, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b1, '{3'd6, 8'h00, 8'h00, 8'h00, 1'b1}},
        '{ROW_CFG,  CFG_TARGET,   8'h07, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_TARGET,   8'h01, 1'b0, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_MODE,     8'hFF, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b0, NO_WRITE},
        '{ROW_CFG,  CFG_MODE,     8'hFD, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b1, '{3'd1, 8'h80, 8'h7F, 8'h01, 1'b0}},
        '{ROW_CFG,  CFG_MODE,     8'h00, 1'b0, 1'b0, NO_WRITE},
        '{ROW_TICK, CFG_MODE,     8'h00, 1'b1, 1'b0, NO_WRITE}
    };

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata  = '0;
    logic                  i_tick_valid = 1'b0;
    logic                  i_tick       = 1'b0;
    logic                  i_res_ready  = 1'b0;
    logic                  o_tick_ready;
    logic                  o_res_valid;
    logic [2:0]            o_led_sel;
    logic [7:0]            o_out_red;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_blue;
    logic                  o_frame_last;

    logic [1:0] fx_mode        = MODE_OFF;
    logic [1:0] fx_speed       = 2'd0;
    logic [7:0] fx_red         = 8'd0;
    logic [7:0] fx_green       = 8'd0;
    logic [7:0] fx_blue        = 8'd0;
    logic [2:0] fx_target      = TARGET_ALL;
    logic [2:0] head_led       = 3'd1;
    logic [7:0] breath_lvl     = 8'd0;
    logic [7:0] ticks_to_frame = 8'd0;

    t_led_write pending_writes[$];

    int err_count      = 0;
    int writes_checked = 0;
    int ticks_sent     = 0;
    int cfg_writes     = 0;
    int tick_stalls    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    led_ring_meteor_breath_effect u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_tick_valid (i_tick_valid),
        .o_tick_ready (o_tick_ready),
        .i_tick       (i_tick),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_led_sel    (o_led_sel),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_frame_last (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        logic known;
        known = 1'b1;
        case (idx)
            CFG_MODE:   fx_mode = data[1:0];
            CFG_SPEED:  fx_speed = (data[1:0] == SPEED_SAT) ? SPEED_MAX : data[1:0];
            CFG_RED:    fx_red = data;
            CFG_GREEN:  fx_green = data;
            CFG_BLUE:   fx_blue = data;
            CFG_TARGET: fx_target = data[2:0];
            default:    known = 1'b0;
        endcase
        if (known) begin
            head_led = 3'd1;
            breath_lvl = 8'd0;
            ticks_to_frame = 8'd0;
        end
    endtask

    task automatic advance_effect(input logic t);
        logic [1:0] sp;
        int         per;
        int         lvl;
        int         ahead;
        t_led_write w;
        sp = (fx_speed > SPEED_MAX) ? SPEED_MAX : fx_speed;
        if (t && fx_mode == MODE_METEOR) begin
            case (sp)
                2'd0:    per = 200;
                2'd1:    per = 140;
                default: per = 80;
            endcase
            if (ticks_to_frame != 0) begin
                ticks_to_frame = ticks_to_frame - 8'd1;
            end else begin
                ticks_to_frame = 8'(per - 1);
                for (int j = 0; j < LED_COUNT; j++) begin
                    ahead = (LED_COUNT - j) % LED_COUNT;
                    w.led = 3'((int'(head_led) - 1 + ahead) % LED_COUNT + 1);
                    if (j == 0) begin
                        w.red = fx_red;
                        w.green = fx_green;
                        w.blue = fx_blue;
                    end else if (j == 1) begin
                        w.red = fx_red >> (sp + 3);
                        w.green = fx_green >> (sp + 3);
                        w.blue = fx_blue >> (sp + 3);
                    end else if (j == 2) begin
                        w.red = fx_red >> (sp + 4);
                        w.green = fx_green >> (sp + 4);
                        w.blue = fx_blue >> (sp + 4);
                    end else begin
                        w.red = 8'd0;
                        w.green = 8'd0;
                        w.blue = 8'd0;
                    end
                    w.last = (j == LED_COUNT - 1);
                    pending_writes.push_back(w);
                end
                head_led = (head_led >= LED_COUNT) ? 3'd1 : head_led + 3'd1;
            end
        end else if (t && fx_mode == MODE_BREATH && fx_target <= LED_COUNT) begin
            case (sp)
                2'd0:    per = 50;
                2'd1:    per = 35;
                default: per = 25;
            endcase
            if (ticks_to_frame != 0) begin
                ticks_to_frame = ticks_to_frame - 8'd1;
            end else begin
                ticks_to_frame = 8'(per - 1);
                lvl = int'(breath_lvl[6:0]);
                w.led = fx_target;
                w.red = 8'((int'(fx_red) * lvl) / per);
                w.green = 8'((int'(fx_green) * lvl) / per);
                w.blue = 8'((int'(fx_blue) * lvl) / per);
                w.last = 1'b1;
                pending_writes.push_back(w);
                if (breath_lvl[7]) begin
                    breath_lvl = breath_lvl - 8'd1;
                    if (breath_lvl <= 8'h81) breath_lvl = 8'h01;
                end else begin
                    breath_lvl = breath_lvl + 8'd1;
                    if (int'(breath_lvl) >= per) breath_lvl = 8'h80 | 8'(per);
                end
            end
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_reg_value(
        input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        int r;
        v = 8'($urandom);
        r = $urandom_range(9);
        case (idx)
            CFG_MODE:   v[1:0] = (r < 4) ? MODE_METEOR : (r < 8) ? MODE_BREATH :
                                 (r == 8) ? MODE_OFF : MODE_UNUSED;
            CFG_SPEED:  v = v;
            CFG_TARGET: v[2:0] = (r == 9) ? TARGET_NONE : 3'($urandom_range(LED_COUNT));
            default: begin
                if (r < 2) v = 8'h00;
                else if (r < 4) v = 8'hFF;
            end
        endcase
        return v;
    endfunction

    task automatic await_idle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_tick_valid <= 1'b0;
        i_cfg_we <= 1'b0;
        while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        await_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_reg_write(idx, data);
        cfg_writes++;
    endtask

    task automatic send_tick(input logic t, input logic typed, input t_led_write want);
        int base;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_tick_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_tick_valid <= 1'b1;
        i_tick <= t;
        do @(posedge i_clk); while (!o_tick_ready);
        base = pending_writes.size();
        advance_effect(t);
        if (typed && pending_writes.size() > base) pending_writes[base] = want;
        ticks_sent++;
    endtask

    // hold off results for a counted stretch when asked, else stall at random
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_led_write exp_w;
        if (i_rst_n && i_tick_valid && !o_tick_ready) tick_stalls++;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected LED write led %0d rgb %02h %02h %02h last %0b",
                         $time, o_led_sel, o_out_red, o_out_green, o_out_blue, o_frame_last);
                err_count++;
            end else begin
                exp_w = pending_writes.pop_front();
                writes_checked++;
                if (o_led_sel !== exp_w.led) begin
                    $display("%0t: led_sel expected %0d got %0d", $time, exp_w.led, o_led_sel);
                    err_count++;
                end
                if (o_out_red !== exp_w.red) begin
                    $display("%0t: out_red expected %02h got %02h", $time, exp_w.red, o_out_red);
                    err_count++;
                end
                if (o_out_green !== exp_w.green) begin
                    $display("%0t: out_green expected %02h got %02h",
                             $time, exp_w.green, o_out_green);
                    err_count++;
                end
                if (o_out_blue !== exp_w.blue) begin
                    $display("%0t: out_blue expected %02h got %02h",
                             $time, exp_w.blue, o_out_blue);
                    err_count++;
                end
                if (o_frame_last !== exp_w.last) begin
                    $display("%0t: frame_last expected %0b got %0b",
                             $time, exp_w.last, o_frame_last);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int                   phase;
        int                   deep_done;
        int                   short_ticks;
        int                   n_items;
        int                   k;
        int                   spd;
        logic                 deep;
        logic                 t;
        logic [CFG_IDX_W-1:0] idx;
        deep_done = 0;
        short_ticks = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].kind == ROW_CFG) begin
                cfg_write(DIR_TABLE[r].idx, DIR_TABLE[r].data);
            end else begin
                send_tick(DIR_TABLE[r].tick, DIR_TABLE[r].typed, DIR_TABLE[r].want);
            end
        end

        for (phase = 0; short_ticks < SHORT_TICK_GOAL || deep_done < DEEP_PHASES; phase++) begin
            deep = (phase % 3 == 2 && deep_done < DEEP_PHASES) ||
                   short_ticks >= SHORT_TICK_GOAL;
            if (deep) begin
                case (deep_done)
                    0: begin spd = 2; n_items = 90;  end
                    1: begin spd = 2; n_items = 110; end
                    2: begin spd = 0; n_items = 40;  end
                    default: begin spd = 1; n_items = 40; end
                endcase
                cfg_write(CFG_MODE, {6'($urandom),
                                     (deep_done == 0) ? MODE_METEOR : MODE_BREATH});
                cfg_write(CFG_SPEED, {6'($urandom), 2'(spd)});
                cfg_write(CFG_RED, random_reg_value(CFG_RED));
                cfg_write(CFG_GREEN, random_reg_value(CFG_GREEN));
                cfg_write(CFG_BLUE, random_reg_value(CFG_BLUE));
                cfg_write(CFG_TARGET, {5'($urandom), 3'($urandom_range(LED_COUNT))});
            end else begin
                n_items = $urandom_range(10, 25);
                for (k = 0; k < 8; k++) begin
                    idx = k[CFG_IDX_W-1:0];
                    if (idx == CFG_SPARE_LO || idx == CFG_SPARE_HI) begin
                        if ($urandom_range(9) == 0) cfg_write(idx, 8'($urandom));
                    end else if (idx == CFG_MODE || $urandom_range(1) == 1) begin
                        cfg_write(idx, random_reg_value(idx));
                    end
                end
            end

            if (deep && deep_done == 1) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                @(posedge i_clk);
                hold_req = LONG_HOLD;
            end else begin
                case (phase % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                    default: begin send_idle_pct = 11; recv_stall_pct = 11; end
                endcase
            end

            for (k = 0; k < n_items; k++) begin
                t = ($urandom_range(99) < 92);
                // drain every pending write mid-phase, without a restart
                if (!deep && phase % 2 == 1 && k == n_items / 2) await_idle();
                send_tick(t, 1'b0, NO_WRITE);
                if (t && !deep) short_ticks++;
            end
            if (deep) deep_done++;
        end

        await_idle();
        if (pending_writes.size() != 0) begin
            $display("%0t: %0d expected LED writes never arrived", $time, pending_writes.size());
            err_count += pending_writes.size();
        end
        $display("run covered %0d tick requests over %0d effect phases and %0d register writes",
                 ticks_sent, phase, cfg_writes);
        $display("%0d LED writes checked; tick input held off for %0d cycles by stalled results",
                 writes_checked, tick_stalls);
        if (err_count == 0) begin
            $display("led_ring_meteor_breath_effect verification clean");
        end else begin
            $display("led_ring_meteor_breath_effect verification failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("led_ring_meteor_breath_effect verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/lrmb_pkg.sv
rtl/core/lrmb_front.sv
rtl/core/lrmb_cmd_fifo.sv
rtl/core/lrmb_back.sv
rtl/core/led_ring_meteor_breath_effect.sv
bench/tb_led_ring_meteor_breath_effect.sv
